FILE: src/mvsm_pkg.sv
// shared types, codes and defaults for the multi-voice sample mixer
package mvsm_pkg;

  localparam int VOICE_COUNT_DEF  = 16;
  localparam int SOUND_COUNT_DEF  = 16;
  localparam int SAMPLE_DEPTH_DEF = 65536;
  localparam int SAMPLE_BITS_DEF  = 16;

  localparam logic [2:0] ACT_LOAD   = 3'd0;
  localparam logic [2:0] ACT_PLAIN  = 3'd1;
  localparam logic [2:0] ACT_LOOPED = 3'd2;
  localparam logic [2:0] ACT_PLAY   = 3'd3;
  localparam logic [2:0] ACT_UPDATE = 3'd4;
  localparam logic [2:0] ACT_STOP   = 3'd5;
  localparam logic [2:0] ACT_TICK   = 3'd6;

  localparam logic REG_SOUND_VOLUME = 1'b0;
  localparam logic REG_MUSIC_VOLUME = 1'b1;

  localparam logic [15:0] UNITY = 16'h8000;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         voice;
    logic [3:0]         sound_id;
    logic [15:0]        address;
    logic signed [15:0] sample_value;
    logic signed [15:0] music_right;
    logic [16:0]        length;
    logic [15:0]        loop_begin;
    logic [16:0]        loop_finish;
    logic [15:0]        gain;
    logic signed [15:0] balance;
    logic [23:0]        step;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [15:0]        active_voices;
  } result_t;

  typedef enum logic [2:0] {
    K_LOAD,
    K_DEFINE,
    K_PLAY,
    K_UPDATE,
    K_STOP,
    K_TICK
  } kind_t;

  typedef struct packed {
    kind_t kind;
    cmd_t  cmd;
  } job_t;

endpackage

FILE: src/mvsm_front.sv
// command intake: classifies each word and drops ones that address nothing
module mvsm_front #(
  parameter int VOICE_COUNT = mvsm_pkg::VOICE_COUNT_DEF,
  parameter int SOUND_COUNT = mvsm_pkg::SOUND_COUNT_DEF
) (
  input  logic           start,
  input  mvsm_pkg::cmd_t cmd,
  input  logic           q_full,
  output logic           busy,
  output logic           push,
  output mvsm_pkg::job_t push_job
);
  import mvsm_pkg::*;

  logic  voice_ok;
  logic  sound_ok;
  logic  keep;
  kind_t kind;

  always_comb begin
    voice_ok = 32'(cmd.voice) < VOICE_COUNT;
    sound_ok = 32'(cmd.sound_id) < SOUND_COUNT;
    kind     = K_TICK;
    keep     = 1'b0;
    case (cmd.action)
      ACT_LOAD: begin
        kind = K_LOAD;
        keep = 1'b1;
      end
      ACT_PLAIN, ACT_LOOPED: begin
        kind = K_DEFINE;
        keep = sound_ok;
      end
      ACT_PLAY: begin
        kind = K_PLAY;
        keep = voice_ok && sound_ok;
      end
      ACT_UPDATE: begin
        kind = K_UPDATE;
        keep = voice_ok;
      end
      ACT_STOP: begin
        kind = K_STOP;
        keep = voice_ok;
      end
      ACT_TICK: begin
        kind = K_TICK;
        keep = 1'b1;
      end
      default: begin
        kind = K_TICK;
        keep = 1'b0;
      end
    endcase
  end

  assign busy     = q_full;
  assign push     = start && !q_full && keep;
  assign push_job = '{kind: kind, cmd: cmd};

endmodule

FILE: src/mvsm_queue.sv
// two-entry job queue between intake and execution
module mvsm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mvsm_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output mvsm_pkg::job_t head
);
  import mvsm_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  job_t          slot [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_job;
  end

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = slot[rd_ptr];

endmodule

FILE: src/mvsm_rem.sv
// bit-serial remainder unit for loop wrap, one bit per cycle
module mvsm_rem (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [33:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [32:0] remainder
);
  localparam int N  = 34;
  localparam int CW = $clog2(N + 1);

  logic [33:0]   rem_r;
  logic [33:0]   quo_r;
  logic [32:0]   div_r;
  logic [CW-1:0] left;
  logic          running;
  logic [33:0]   rs;

  assign rs = {rem_r[32:0], quo_r[33]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      left    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        left    <= CW'(N);
      end else if (running) begin
        left <= left - CW'(1);
        if (left == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (running) begin
      rem_r <= (rs >= {1'b0, div_r}) ? rs - {1'b0, div_r} : rs;
      quo_r <= {quo_r[32:0], 1'b0};
    end
  end

  assign remainder = rem_r[32:0];

endmodule

FILE: src/mvsm_back.sv
// execution side: sample memory, sound and voice tables, per-voice mix sequencer
module mvsm_back #(
  parameter int VOICE_COUNT  = mvsm_pkg::VOICE_COUNT_DEF,
  parameter int SOUND_COUNT  = mvsm_pkg::SOUND_COUNT_DEF,
  parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF,
  parameter int SAMPLE_BITS  = mvsm_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              q_not_empty,
  input  mvsm_pkg::job_t    q_head,
  output logic              q_pop,
  output logic              done,
  output mvsm_pkg::result_t result
);
  import mvsm_pkg::*;

  localparam int VI_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int SI_W  = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
  localparam int AW    = $clog2(SAMPLE_DEPTH);
  localparam int SB    = SAMPLE_BITS;
  localparam int SHR   = (SB >= 16) ? SB - 16 : 0;
  localparam int SHL   = (SB < 16) ? 16 - SB : 0;
  localparam int ACC_W = 20 + $clog2(VOICE_COUNT + 1);
  localparam logic [VI_W-1:0] LAST_VOICE = VI_W'(VOICE_COUNT - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_FETCH  = 14'b00000000000010,
    ST_FETCH2 = 14'b00000000000100,
    ST_PREP   = 14'b00000000001000,
    ST_ADDR   = 14'b00000000010000,
    ST_RD0    = 14'b00000000100000,
    ST_RD1    = 14'b00000001000000,
    ST_MUL0   = 14'b00000010000000,
    ST_MUL1   = 14'b00000100000000,
    ST_INTERP = 14'b00001000000000,
    ST_MIX    = 14'b00010000000000,
    ST_ACC    = 14'b00100000000000,
    ST_WRAP   = 14'b01000000000000,
    ST_OUT    = 14'b10000000000000
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [15:0] base, input logic [16:0] idx);
    logic [17:0]    s;
    logic [AW+17:0] w;
    s = {2'b00, base} + {1'b0, idx};
    w = {{AW{1'b0}}, s};
    return w[AW-1:0];
  endfunction

  // storage
  logic [SB-1:0]   sample_store [SAMPLE_DEPTH];
  logic [15:0]     snd_start    [SOUND_COUNT];
  logic [16:0]     snd_len      [SOUND_COUNT];
  logic [15:0]     snd_lb       [SOUND_COUNT];
  logic [16:0]     snd_lf       [SOUND_COUNT];
  logic            snd_looped   [SOUND_COUNT];
  logic [SI_W-1:0] v_sound      [VOICE_COUNT];
  logic [15:0]     v_gain       [VOICE_COUNT];
  logic [15:0]     v_bal        [VOICE_COUNT];
  logic [23:0]     v_step       [VOICE_COUNT];
  logic [32:0]     v_pos        [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] voice_on;

  logic [15:0] sound_volume;
  logic [15:0] music_volume;
  state_t      state;
  logic [VI_W-1:0] k;

  // registered table reads
  logic [SI_W-1:0] vr_sound;
  logic [15:0]     vr_gain;
  logic signed [15:0] vr_bal;
  logic [23:0]     vr_step;
  logic [32:0]     vr_pos;
  logic [15:0]     sr_start;
  logic [16:0]     sr_len;
  logic [15:0]     sr_lb;
  logic [16:0]     sr_lf;
  logic            sr_looped;
  logic [SB-1:0]   rdata;

  // datapath registers
  logic [32:0] p0_r;
  logic [33:0] p1_r;
  logic [16:0] g1l_r, g1r_r;
  logic [15:0] lv_r, rv_r;
  logic [AW-1:0] a0_r, a1_r;
  logic [15:0] t_r;
  logic signed [SB-1:0]  s0_r, s1_r;
  logic signed [SB+17:0] prod0_r, prod1_r;
  logic signed [15:0]    val_r;
  logic signed [32:0]    cl_r, cr_r;
  logic [33:0]           pos_sum_r;
  logic signed [ACC_W-1:0] acc_l, acc_r;

  // job decode
  job_t            job;
  logic [VI_W+3:0] vwide;
  logic [SI_W+3:0] swide;
  logic [AW+15:0]  awide;
  logic [SB+15:0]  wwide;
  logic [VI_W-1:0] vidx;
  logic [SI_W-1:0] sidx;
  logic [AW-1:0]   aidx;
  logic [SB-1:0]   sword;
  logic [16:0]     lmax;
  logic [15:0]     lb_c;
  logic [16:0]     lf_c;
  logic            looped_def;

  assign job   = q_head;
  assign q_pop = (state == ST_IDLE) && q_not_empty;
  assign vwide = {{VI_W{1'b0}}, job.cmd.voice};
  assign swide = {{SI_W{1'b0}}, job.cmd.sound_id};
  assign awide = {{AW{1'b0}}, job.cmd.address};
  assign wwide = {{SB{1'b0}}, job.cmd.sample_value};
  assign vidx  = vwide[VI_W-1:0];
  assign sidx  = swide[SI_W-1:0];
  assign aidx  = awide[AW-1:0];
  assign sword = wwide[SB-1:0];
  assign lmax  = job.cmd.length - 17'd1;
  assign lb_c  = ({1'b0, job.cmd.loop_begin} > lmax) ? lmax[15:0] : job.cmd.loop_begin;
  assign lf_c  = (job.cmd.loop_finish > job.cmd.length) ? job.cmd.length : job.cmd.loop_finish;
  assign looped_def = (job.cmd.action == ACT_LOOPED) && (job.cmd.length != 17'd0);

  // voice datapath
  logic [32:0] e_w, l_w;
  logic        loop_w;
  logic [33:0] p1_full;
  logic [15:0] fac_l, fac_r;
  logic [31:0] gl_prod, gr_prod;
  logic [32:0] g2l_prod, g2r_prod;
  logic [16:0] srcmax;
  logic [16:0] i0, i0c, i1c;
  logic [17:0] i1;
  logic [16:0] w0;
  logic signed [SB+18:0] isum, inorm;
  logic signed [32:0] ml_prod, mr_prod;
  logic signed [17:0] cl_sh, cr_sh;
  logic [33:0] diff;
  logic        ge_e, fast, end_plain;
  logic [AW-1:0] rd_addr;
  logic        rem_go, rem_done;
  logic [32:0] rem_out;
  logic        pos_we;
  logic [VI_W-1:0] pos_waddr;
  logic [32:0] pos_wdata;
  logic [VOICE_COUNT+15:0] on_pad;

  assign e_w     = {sr_lf, 16'h0000};
  assign l_w     = {sr_lf - {1'b0, sr_lb}, 16'h0000};
  assign loop_w  = sr_looped && (sr_lf > {1'b0, sr_lb});
  assign p1_full = {1'b0, vr_pos} + 34'h10000;
  assign fac_l   = (vr_bal > 16'sd0) ? UNITY - vr_bal : UNITY;
  assign fac_r   = (vr_bal < 16'sd0) ? UNITY + vr_bal : UNITY;
  assign gl_prod = {16'h0000, vr_gain} * {16'h0000, fac_l};
  assign gr_prod = {16'h0000, vr_gain} * {16'h0000, fac_r};
  assign g2l_prod = {16'h0000, g1l_r} * {17'h00000, sound_volume};
  assign g2r_prod = {16'h0000, g1r_r} * {17'h00000, sound_volume};
  assign srcmax  = sr_len - 17'd1;
  assign i0      = p0_r[32:16];
  assign i0c     = (i0 > srcmax) ? srcmax : i0;
  assign i1      = p1_r[33:16];
  assign i1c     = (i1 > {1'b0, srcmax}) ? srcmax : i1[16:0];
  assign w0      = 17'h10000 - {1'b0, t_r};
  assign isum    = prod0_r + prod1_r;
  assign inorm   = ((isum >>> 16) >>> SHR) <<< SHL;
  assign ml_prod = job.cmd.sample_value * $signed({1'b0, music_volume});
  assign mr_prod = job.cmd.music_right * $signed({1'b0, music_volume});
  assign cl_sh   = cl_r[32:15];
  assign cr_sh   = cr_r[32:15];
  assign diff    = pos_sum_r - {1'b0, e_w};
  assign ge_e    = pos_sum_r >= {1'b0, e_w};
  assign fast    = diff < {1'b0, l_w};
  assign end_plain = pos_sum_r >= {1'b0, sr_len, 16'h0000};
  assign rd_addr = (state == ST_RD0) ? a0_r : a1_r;
  assign rem_go  = (state == ST_ACC) && loop_w && ge_e && !fast;
  assign on_pad  = {16'h0000, voice_on};

  mvsm_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .go        (rem_go),
    .dividend  (diff),
    .divisor   (l_w),
    .done      (rem_done),
    .remainder (rem_out)
  );

  always_comb begin
    pos_we    = 1'b0;
    pos_waddr = k;
    pos_wdata = pos_sum_r[32:0];
    case (state)
      ST_IDLE: begin
        pos_we    = q_not_empty && (job.kind == K_PLAY);
        pos_waddr = vidx;
        pos_wdata = '0;
      end
      ST_ACC: begin
        if (loop_w) begin
          pos_we = !(ge_e && !fast);
          if (ge_e) pos_wdata = {sr_lb, 16'h0000} + diff[32:0];
        end else begin
          pos_we = !end_plain;
        end
      end
      ST_WRAP: begin
        pos_we    = rem_done;
        pos_wdata = {sr_lb, 16'h0000} + rem_out;
      end
      default: pos_we = 1'b0;
    endcase
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (q_pop && job.kind == K_LOAD) sample_store[aidx] <= sword;
    rdata <= sample_store[rd_addr];
  end

  // sound descriptors
  always_ff @(posedge clk) begin
    if (q_pop && job.kind == K_DEFINE) begin
      snd_start[sidx]  <= job.cmd.address;
      snd_len[sidx]    <= job.cmd.length;
      snd_lb[sidx]     <= looped_def ? lb_c : 16'h0000;
      snd_lf[sidx]     <= looped_def ? lf_c : 17'h00000;
      snd_looped[sidx] <= looped_def;
    end
    sr_start  <= snd_start[vr_sound];
    sr_len    <= snd_len[vr_sound];
    sr_lb     <= snd_lb[vr_sound];
    sr_lf     <= snd_lf[vr_sound];
    sr_looped <= snd_looped[vr_sound];
  end

  // voice tables
  always_ff @(posedge clk) begin
    if (q_pop && (job.kind == K_PLAY || (job.kind == K_UPDATE && voice_on[vidx]))) begin
      v_gain[vidx] <= job.cmd.gain;
      v_bal[vidx]  <= job.cmd.balance;
      v_step[vidx] <= job.cmd.step;
    end
    if (q_pop && job.kind == K_PLAY) v_sound[vidx] <= sidx;
    if (pos_we) v_pos[pos_waddr] <= pos_wdata;
    vr_sound <= v_sound[k];
    vr_gain  <= v_gain[k];
    vr_bal   <= v_bal[k];
    vr_step  <= v_step[k];
    vr_pos   <= v_pos[k];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      k            <= '0;
      voice_on     <= '0;
      done         <= 1'b0;
      sound_volume <= UNITY;
      music_volume <= UNITY;
    end else begin
      done <= state == ST_OUT;
      if (cfg_we) begin
        case (cfg_index)
          REG_SOUND_VOLUME: sound_volume <= cfg_data;
          REG_MUSIC_VOLUME: music_volume <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (q_not_empty) begin
            case (job.kind)
              K_PLAY: voice_on[vidx] <= 1'b1;
              K_STOP: voice_on[vidx] <= 1'b0;
              K_TICK: begin
                k     <= '0;
                state <= ST_FETCH;
              end
              default: ;
            endcase
          end
        end
        ST_FETCH: begin
          if (!voice_on[k]) begin
            if (k == LAST_VOICE) state <= ST_OUT;
            else begin
              k     <= k + VI_W'(1);
              state <= ST_FETCH;
            end
          end else begin
            state <= ST_FETCH2;
          end
        end
        ST_FETCH2: state <= ST_PREP;
        ST_PREP: begin
          if (sr_len == 17'd0) begin
            voice_on[k] <= 1'b0;
            if (k == LAST_VOICE) state <= ST_OUT;
            else begin
              k     <= k + VI_W'(1);
              state <= ST_FETCH;
            end
          end else begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR:   state <= ST_RD0;
        ST_RD0:    state <= ST_RD1;
        ST_RD1:    state <= ST_MUL0;
        ST_MUL0:   state <= ST_MUL1;
        ST_MUL1:   state <= ST_INTERP;
        ST_INTERP: state <= ST_MIX;
        ST_MIX:    state <= ST_ACC;
        ST_ACC: begin
          if (rem_go) begin
            state <= ST_WRAP;
          end else begin
            if (!loop_w && end_plain) voice_on[k] <= 1'b0;
            if (k == LAST_VOICE) state <= ST_OUT;
            else begin
              k     <= k + VI_W'(1);
              state <= ST_FETCH;
            end
          end
        end
        ST_WRAP: begin
          if (rem_done) begin
            if (k == LAST_VOICE) state <= ST_OUT;
            else begin
              k     <= k + VI_W'(1);
              state <= ST_FETCH;
            end
          end
        end
        ST_OUT:  state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_not_empty && job.kind == K_TICK) begin
          acc_l <= {{(ACC_W-18){ml_prod[32]}}, ml_prod[32:15]};
          acc_r <= {{(ACC_W-18){mr_prod[32]}}, mr_prod[32:15]};
        end
      end
      ST_PREP: begin
        p0_r  <= (loop_w && vr_pos >= e_w) ? vr_pos - l_w : vr_pos;
        p1_r  <= (loop_w && p1_full >= {1'b0, e_w}) ? p1_full - {1'b0, l_w} : p1_full;
        g1l_r <= gl_prod[31:15];
        g1r_r <= gr_prod[31:15];
      end
      ST_ADDR: begin
        lv_r <= (g2l_prod[32:15] > 18'd32768) ? UNITY : g2l_prod[30:15];
        rv_r <= (g2r_prod[32:15] > 18'd32768) ? UNITY : g2r_prod[30:15];
        a0_r <= addr_of(sr_start, i0c);
        a1_r <= addr_of(sr_start, i1c);
        t_r  <= p0_r[15:0];
      end
      ST_RD1:    s0_r <= rdata;
      ST_MUL0: begin
        s1_r    <= rdata;
        prod0_r <= s0_r * $signed({1'b0, w0});
      end
      ST_MUL1:   prod1_r <= s1_r * $signed({2'b00, t_r});
      ST_INTERP: val_r <= inorm[15:0];
      ST_MIX: begin
        cl_r      <= val_r * $signed({1'b0, lv_r});
        cr_r      <= val_r * $signed({1'b0, rv_r});
        pos_sum_r <= {1'b0, vr_pos} + {10'h000, vr_step};
      end
      ST_ACC: begin
        acc_l <= acc_l + {{(ACC_W-18){cl_sh[17]}}, cl_sh};
        acc_r <= acc_r + {{(ACC_W-18){cr_sh[17]}}, cr_sh};
      end
      ST_OUT: begin
        result.left_out  <= (acc_l > SAT_HI) ? 16'sh7fff :
                            (acc_l < SAT_LO) ? 16'sh8000 : acc_l[15:0];
        result.right_out <= (acc_r > SAT_HI) ? 16'sh7fff :
                            (acc_r < SAT_LO) ? 16'sh8000 : acc_r[15:0];
        result.active_voices <= on_pad[15:0];
      end
      default: ;
    endcase
  end

endmodule

FILE: src/multi_voice_sample_mixer_core.sv
// top level of the multi-voice sample mixer
// a command word is taken whenever busy is low; non-tick words are applied as they are popped from the queue
// a tick walks the voices in order: idle voices are skipped, a voice on an empty sound is
// switched off, every other active voice is mixed, with the serial remainder unit used when a
// loop wrap needs it; then done pulses for one cycle with the frame; the receiver cannot stall.
// reset clears voice activity, the queue and the sequencer and sets both volumes to
// unity; samples, sounds and voice data stay undefined until written, no clearing pass.
module multi_voice_sample_mixer_core #(
  parameter int VOICE_COUNT  = mvsm_pkg::VOICE_COUNT_DEF,
  parameter int SOUND_COUNT  = mvsm_pkg::SOUND_COUNT_DEF,
  parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF,
  parameter int SAMPLE_BITS  = mvsm_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mvsm_pkg::cmd_t    cmd,
  output logic              done,
  output mvsm_pkg::result_t result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);
  import mvsm_pkg::*;

  logic push;
  job_t push_job;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  job_t q_head;

  mvsm_front #(
    .VOICE_COUNT (VOICE_COUNT),
    .SOUND_COUNT (SOUND_COUNT)
  ) u_front (
    .start    (start),
    .cmd      (cmd),
    .q_full   (q_full),
    .busy     (busy),
    .push     (push),
    .push_job (push_job)
  );

  mvsm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mvsm_back #(
    .VOICE_COUNT  (VOICE_COUNT),
    .SOUND_COUNT  (SOUND_COUNT),
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .done        (done),
    .result      (result)
  );

endmodule
